FILE: rtl/lsc_pkg.sv
// Shared constants, types and helpers of the limited slope calculator.
// Used by every module in the rtl folder; depends on nothing else.
package lsc_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DIFF_W        = DATA_WIDTH + 1;
  localparam int FACT_W        = DATA_WIDTH - 1;
  localparam int PROD_W        = DIFF_W + FACT_W;
  localparam int MAG_W         = PROD_W - FRACTION_BITS;
  localparam int QUO_W         = DATA_WIDTH;
  localparam int DEN_W         = MAG_W + 1;
  localparam int NUM_W         = QUO_W + MAG_W;
  localparam int IN_BITS       = 3 * DATA_WIDTH + 3 * FACT_W;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  localparam logic [1:0] MODE_DONOR    = 2'd0;
  localparam logic [1:0] MODE_VAN_LEER = 2'd1;
  localparam logic [1:0] MODE_WOODWARD = 2'd2;

  // Per-item information that rides alongside the divider.
  typedef struct packed {
    logic                  neg;
    logic                  sat;
    logic                  use_vl;
    logic [DATA_WIDTH-1:0] wres;
  } side_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    side_t            side;
  } div_t;

  // Sign and magnitude to saturated two's complement.
  function automatic logic [DATA_WIDTH-1:0] sat_encode(input logic neg,
                                                       input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] half;
    logic [MAG_W-1:0] lim;
    half = MAG_W'(1) << (DATA_WIDTH - 1);
    if (neg) begin
      lim = (mag > half) ? half : mag;
      return DATA_WIDTH'(~lim + MAG_W'(1));
    end else begin
      lim = (mag > half - MAG_W'(1)) ? half - MAG_W'(1) : mag;
      return DATA_WIDTH'(lim);
    end
  endfunction

endpackage

FILE: rtl/lsc_scale.sv
// Two-stage scaled difference: (a - b) * factor, as sign and magnitude.
// Depends on lsc_pkg.
module lsc_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lsc_pkg::DATA_WIDTH-1:0] a,
  input  logic [lsc_pkg::DATA_WIDTH-1:0] b,
  input  logic [lsc_pkg::FACT_W-1:0]     factor,
  output logic                          neg,
  output logic [lsc_pkg::MAG_W-1:0]     mag
);
  import lsc_pkg::*;

  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] dmag;
  logic              sgn1;
  logic [FACT_W-1:0] fac1;
  logic              sgn2;
  logic [PROD_W-1:0] prod;

  // Exact difference, one bit wider than the data.
  assign diff = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};

  // First stage holds the magnitude, second the full product.
  always_ff @(posedge clk) begin
    if (en) begin
      sgn1 <= diff[DIFF_W-1];
      dmag <= diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      fac1 <= factor;
      sgn2 <= sgn1;
      prod <= PROD_W'(dmag) * PROD_W'(fac1);
    end
  end

  // Truncating shift to the fixed-point scale; zero carries no sign.
  assign mag = prod[PROD_W-1:FRACTION_BITS];
  assign neg = sgn2 && (mag != '0);

endmodule

FILE: rtl/lsc_div_step.sv
// One registered step of the restoring divider for the harmonic mean.
// Depends on lsc_pkg.
module lsc_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  lsc_pkg::div_t   in_data,
  output logic            out_valid,
  output lsc_pkg::div_t   out_data
);
  import lsc_pkg::*;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           take;
  div_t           nxt;

  // Bring down one numerator bit and try the subtraction.
  always_comb begin
    trial = {in_data.rem, in_data.low[QUO_W-1]};
    diff  = trial - {1'b0, in_data.den};
    take  = !diff[DEN_W];
    nxt      = in_data;
    nxt.rem  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    nxt.low  = in_data.low << 1;
    nxt.quo  = {in_data.quo[QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

FILE: rtl/limited_slope_calc.sv
// Top level of the limited slope calculator: input pipeline, limiter
// select, harmonic-mean divider chain and output register. Uses lsc_pkg,
// lsc_scale and lsc_div_step.
//
// Usage: each input item on s_tdata carries a cell's left, center and right
// values and three inverse spacings; one item on m_tdata returns the
// limited half slope, signed Q16.16, saturated. The limiter mode is set
// through limiter_mode_we / limiter_mode_data while the block is idle.
// Modes: donor cell gives zero, van Leer gives the harmonic mean, Woodward
// gives the monotonized-central minimum.
// Throughput is one item per cycle unless the receiver stalls; the depth is set
// by the 32 single-bit divider stages.
// Reset clears all valid bits and sets the mode to van Leer.
// When the receiver stalls the whole pipeline holds; s_tready is low only
// while the output register holds an item that is not taken.
module limited_slope_calc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            limiter_mode_we,
  input  logic [1:0]                      limiter_mode_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // left_value, center_value, right_value, inv_spacing_minus,
  // inv_spacing_plus, inv_span_center, zero pad (lowest first)
  input  logic [lsc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // limited_slope
  output logic [lsc_pkg::DATA_WIDTH-1:0]  m_tdata
);
  import lsc_pkg::*;

  localparam int DIV_STEPS = QUO_W;
  localparam int F0 = 3 * DATA_WIDTH;

  logic [1:0] mode;
  logic       en;
  logic       v1, v2, v3, v4, v5;
  logic [1:0] mode1, mode2;

  logic [DATA_WIDTH-1:0] left_value, center_value, right_value;
  logic [FACT_W-1:0]     inv_spacing_minus, inv_spacing_plus, inv_span_center;

  logic             dm_neg, dp_neg, dc_neg;
  logic [MAG_W-1:0] dm_mag, dp_mag, dc_mag;

  logic             agree;
  logic [MAG_W-1:0] hc, wmag, vmin_c, vmax_c;
  logic             wneg;

  logic [QUO_W-1:0] vmin3;
  logic [MAG_W-1:0] vmax3;
  logic [DEN_W-1:0] den3, den4;
  side_t            side3, side4;
  logic [2*QUO_W-1:0]       pp_lo;
  logic [QUO_W+MAG_W-QUO_W+QUO_W-1:0] pp_hi;
  logic [NUM_W-1:0] num;
  div_t             div5;

  logic             dv [DIV_STEPS+1];
  div_t             dd [DIV_STEPS+1];
  logic [MAG_W-1:0] vl_mag;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_VAN_LEER;
    end else if (limiter_mode_we) begin
      mode <= limiter_mode_data;
    end
  end

  // The whole pipeline advances unless the output item is stalled.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign left_value        = s_tdata[DATA_WIDTH-1:0];
  assign center_value      = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign right_value       = s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
  assign inv_spacing_minus = s_tdata[F0+FACT_W-1:F0];
  assign inv_spacing_plus  = s_tdata[F0+2*FACT_W-1:F0+FACT_W];
  assign inv_span_center   = s_tdata[F0+3*FACT_W-1:F0+2*FACT_W];

  // Stages one and two: the three scaled differences.
  lsc_scale u_dm (.clk(clk), .en(en), .a(center_value), .b(left_value),
                  .factor(inv_spacing_minus), .neg(dm_neg), .mag(dm_mag));
  lsc_scale u_dp (.clk(clk), .en(en), .a(right_value), .b(center_value),
                  .factor(inv_spacing_plus), .neg(dp_neg), .mag(dp_mag));
  lsc_scale u_dc (.clk(clk), .en(en), .a(right_value), .b(left_value),
                  .factor(inv_span_center), .neg(dc_neg), .mag(dc_mag));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Woodward choice and van Leer operands.
  always_comb begin
    agree = (dm_mag != '0) && (dp_mag != '0) && (dm_neg == dp_neg);
    hc    = dc_mag >> 1;
    if (dm_mag < dp_mag && dm_mag < hc) begin
      wmag = dm_mag;
      wneg = dm_neg;
    end else if (dp_mag < hc) begin
      wmag = dp_mag;
      wneg = dp_neg;
    end else begin
      wmag = hc;
      wneg = dc_neg && (hc != '0);
    end
    vmin_c = (dm_mag < dp_mag) ? dm_mag : dp_mag;
    vmax_c = (dm_mag < dp_mag) ? dp_mag : dm_mag;
  end

  // Stage three register.
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode;
      mode2 <= mode1;
      vmin3 <= vmin_c[QUO_W-1:0];
      vmax3 <= vmax_c;
      den3  <= DEN_W'(dm_mag) + DEN_W'(dp_mag);
      side3.neg    <= dm_neg;
      side3.sat    <= (dm_mag[MAG_W-1:QUO_W] != '0) && (dp_mag[MAG_W-1:QUO_W] != '0);
      side3.use_vl <= (mode2 == MODE_VAN_LEER) && agree;
      side3.wres   <= ((mode2 == MODE_WOODWARD) && agree) ? sat_encode(wneg, wmag) : '0;
    end
  end

  // Stage four: partial products of the numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= (2*QUO_W)'(vmin3) * (2*QUO_W)'(vmax3[QUO_W-1:0]);
      pp_hi <= $bits(pp_hi)'(vmin3) * $bits(pp_hi)'(vmax3[MAG_W-1:QUO_W]);
      den4  <= den3;
      side4 <= side3;
    end
  end

  // Stage five: full numerator, split for the divider.
  assign num = NUM_W'(pp_lo) + (NUM_W'(pp_hi) << QUO_W);

  always_ff @(posedge clk) begin
    if (en) begin
      div5.rem  <= DEN_W'(num[NUM_W-1:QUO_W]);
      div5.den  <= den4;
      div5.low  <= num[QUO_W-1:0];
      div5.quo  <= '0;
      div5.side <= side4;
    end
  end

  assign dv[0] = v5;
  assign dd[0] = div5;

  // Divider chain, one quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    lsc_div_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[k]), .in_data(dd[k]),
      .out_valid(dv[k+1]), .out_data(dd[k+1])
    );
  end

  assign vl_mag = dd[DIV_STEPS].side.sat ? '1 : MAG_W'(dd[DIV_STEPS].quo);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= dd[DIV_STEPS].side.use_vl ? sat_encode(dd[DIV_STEPS].side.neg, vl_mag)
                                           : dd[DIV_STEPS].side.wres;
    end
  end

endmodule

FILE: rtl/lsc_checker.sv
// Port-level checks of the limited slope calculator, bound to the top.
// Depends on lsc_pkg and limited_slope_calc.
module lsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lsc_pkg::DATA_WIDTH-1:0]  m_tdata
);
  import lsc_pkg::*;

  // A stalled output item stays and keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // No output item directly after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Input is refused only while the output is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

bind limited_slope_calc lsc_checker u_lsc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
